// ===== hdl/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// Types, constants and helpers shared by the box polygon clipper modules.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int POS_W     = 24;  // position component, Q15.8
  localparam int NRM_W     = 16;  // normal component, Q1.14
  localparam int AX_W      = 48;  // three Q1.14 axis components
  localparam int SL_W      = 64;  // two Q23.8 slab bounds
  localparam int CIDX_W    = 3;   // config register index
  localparam int VCNT_W    = 5;   // vertex count, 0 to 31
  localparam int MIN_VERTS = 3;   // smallest well-formed polygon
  localparam int QDEPTH    = 4;   // front to back queue entries
  localparam int PROD_W    = 40;  // axis times position
  localparam int DIST_W    = 49;  // plane distance, Q.22
  localparam int REM_W     = 50;  // divider remainder and divisor
  localparam int T_W       = 16;  // crossing fraction, Q0.16
  localparam int CMP_W     = 25;  // widened component for interpolation
  localparam int LP_W      = CMP_W + T_W + 1;
  localparam int NCOMP     = 6;   // components per vertex
  localparam int NPLANES   = 6;
  localparam int BND_SH    = 14;  // bound scale to Q.22

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [NRM_W-1:0] nrm_t;

  typedef struct packed {
    pos_t px;
    pos_t py;
    pos_t pz;
    nrm_t nx;
    nrm_t ny;
    nrm_t nz;
  } vtx_t;

  localparam int VTX_W = 3 * POS_W + 3 * NRM_W;

  // one classified input transaction
  typedef struct packed {
    vtx_t              vtx;
    logic              keep;
    logic              last;
    logic              bad;
    logic [VCNT_W-1:0] cnt;
  } qent_t;

  typedef struct packed {
    logic [2:0][AX_W-1:0] axis;
    logic [2:0][SL_W-1:0] slab;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_VTX       = 2'd0,
    ST_CLIPPED   = 2'd1,
    ST_MALFORMED = 2'd2
  } status_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_TAN_AXIS = 3'd0,
    REG_NRM_AXIS = 3'd1,
    REG_BIN_AXIS = 3'd2,
    REG_TAN_SLAB = 3'd3,
    REG_NRM_SLAB = 3'd4,
    REG_BIN_SLAB = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_FRD,
    B_FMUL,
    B_FSUM,
    B_DEC,
    B_DIV,
    B_LERP,
    B_WRX,
    B_WRC,
    B_MARK,
    B_ERD,
    B_ELD
  } bstate_t;

  typedef enum logic [1:0] {
    PH_CNT,
    PH_PREV,
    PH_WALK
  } phase_t;

  // component j of a vertex, sign extended
  function automatic logic signed [CMP_W-1:0] vtx_comp(vtx_t v, logic [2:0] j);
    logic signed [CMP_W-1:0] c;
    case (j)
      3'd0:    c = CMP_W'(v.px);
      3'd1:    c = CMP_W'(v.py);
      3'd2:    c = CMP_W'(v.pz);
      3'd3:    c = CMP_W'(v.nx);
      3'd4:    c = CMP_W'(v.ny);
      3'd5:    c = CMP_W'(v.nz);
      default: c = '0;
    endcase
    return c;
  endfunction

  // replace component j of a vertex
  function automatic vtx_t vtx_set(vtx_t v, logic [2:0] j, logic [CMP_W-1:0] val);
    vtx_t r;
    r = v;
    case (j)
      3'd0:    r.px = val[POS_W-1:0];
      3'd1:    r.py = val[POS_W-1:0];
      3'd2:    r.pz = val[POS_W-1:0];
      3'd3:    r.nx = val[NRM_W-1:0];
      3'd4:    r.ny = val[NRM_W-1:0];
      3'd5:    r.nz = val[NRM_W-1:0];
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/bpc_ifs.sv =====
// ----------------------------------------------------------------------------
// bpc channel interfaces
// Valid/ready channels for vertices in, clipped vertices out and config.
// ----------------------------------------------------------------------------
interface bpc_in_if;
  logic        valid;
  logic        ready;
  bpc_pkg::pos_t in_px;
  bpc_pkg::pos_t in_py;
  bpc_pkg::pos_t in_pz;
  bpc_pkg::nrm_t in_nx;
  bpc_pkg::nrm_t in_ny;
  bpc_pkg::nrm_t in_nz;
  logic        in_last;
  modport source (output valid, in_px, in_py, in_pz, in_nx, in_ny, in_nz, in_last,
                  input ready);
  modport sink (input valid, in_px, in_py, in_pz, in_nx, in_ny, in_nz, in_last,
                output ready);
endinterface

interface bpc_out_if;
  logic        valid;
  logic        ready;
  bpc_pkg::pos_t out_px;
  bpc_pkg::pos_t out_py;
  bpc_pkg::pos_t out_pz;
  bpc_pkg::nrm_t out_nx;
  bpc_pkg::nrm_t out_ny;
  bpc_pkg::nrm_t out_nz;
  logic [1:0]  out_status;
  logic        out_last;
  modport source (output valid, out_px, out_py, out_pz, out_nx, out_ny, out_nz,
                  out_status, out_last, input ready);
  modport sink (input valid, out_px, out_py, out_pz, out_nx, out_ny, out_nz,
                out_status, out_last, output ready);
endinterface

interface bpc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [bpc_pkg::CIDX_W-1:0]   index;
  logic [bpc_pkg::SL_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/bpc_ram.sv =====
// ----------------------------------------------------------------------------
// bpc_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/bpc_front.sv =====
// ----------------------------------------------------------------------------
// bpc_front
// Takes input vertices, counts them and tags each transaction for the back.
// ----------------------------------------------------------------------------
module bpc_front #(
  parameter int IN_VERTS = 3
) (
  input  logic            clk,
  input  logic            rst_n,
  bpc_in_if.sink          in_ch,
  output logic            push,
  output bpc_pkg::qent_t  ent,
  input  logic            full
);
  import bpc_pkg::*;

  logic [VCNT_W-1:0] cnt_r, cnt_nxt, cnt_after;
  logic              ovf_r, ovf_nxt, ovf_after;
  logic              keep;

  // classify the incoming vertex
  always_comb begin
    keep      = cnt_r < VCNT_W'(IN_VERTS);
    cnt_after = keep ? cnt_r + 1'b1 : cnt_r;
    ovf_after = ovf_r || !keep;
  end

  assign in_ch.ready = !full;
  assign push        = in_ch.valid && !full;

  always_comb begin
    ent.vtx.px = in_ch.in_px;
    ent.vtx.py = in_ch.in_py;
    ent.vtx.pz = in_ch.in_pz;
    ent.vtx.nx = in_ch.in_nx;
    ent.vtx.ny = in_ch.in_ny;
    ent.vtx.nz = in_ch.in_nz;
    ent.keep   = keep;
    ent.last   = in_ch.in_last;
    ent.bad    = ovf_after || (cnt_after < VCNT_W'(MIN_VERTS));
    ent.cnt    = cnt_after;
  end

  // count and overflow restart after the final vertex
  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (push) begin
      cnt_nxt = in_ch.in_last ? '0 : cnt_after;
      ovf_nxt = in_ch.in_last ? 1'b0 : ovf_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule

// ===== hdl/bpc_queue.sv =====
// ----------------------------------------------------------------------------
// bpc_queue
// Short FIFO of classified vertex transactions between front and back.
// ----------------------------------------------------------------------------
module bpc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bpc_pkg::qent_t push_ent,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output bpc_pkg::qent_t head
);
  import bpc_pkg::*;

  localparam int QA = $clog2(QDEPTH);

  qent_t         mem_r [QDEPTH];
  logic [QA-1:0] wp_r, rp_r;
  logic [QA:0]   cnt_r;
  logic          do_push, do_pop;

  assign full       = cnt_r == (QA+1)'(QDEPTH);
  assign head_valid = cnt_r != '0;
  assign head       = mem_r[rp_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_ent;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QA+1)'(do_push) - (QA+1)'(do_pop);
    end
  end

endmodule

// ===== hdl/bpc_back.sv =====
// ----------------------------------------------------------------------------
// bpc_back
// Clip engine: stores the polygon, runs up to six plane passes, emits output.
// ----------------------------------------------------------------------------
module bpc_back #(
  parameter int MAX_VERTS = 9
) (
  input  logic           clk,
  input  logic           rst_n,
  input  bpc_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  bpc_pkg::qent_t q_head,
  output logic           q_pop,
  bpc_out_if.source      out_ch
);
  import bpc_pkg::*;

  localparam int DEPTH = 2 * MAX_VERTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int VI_W  = $clog2(MAX_VERTS);
  localparam int CW    = $clog2(MAX_VERTS + 1);
  localparam int SW    = $clog2(T_W);

  bstate_t   state_r, state_nxt;
  phase_t    phase_r;
  logic [2:0]      k_r;
  logic            buf_r;
  logic [CW-1:0]   n_r, out_cnt_r, nout_r, nout_nxt, cnt_inc, cnt_after;
  logic [VI_W-1:0] a_r, a_last;
  vtx_t            cur_r, prev_r, nv_r, ram_q, in_v, out_v;
  logic signed [DIST_W-1:0] cur_d_r, prev_d_r, d_in, d_out;
  logic signed [PROD_W-1:0] prod_r [3];
  logic            cx_cur_r, copy_after_r;
  logic [REM_W-1:0] rem_r, den_r, r2;
  logic [T_W-1:0]  q_r;
  logic [SW-1:0]   step_r;
  logic [2:0]      lj_r;
  logic signed [LP_W-1:0]  lprod_r, lsh;
  logic signed [CMP_W-1:0] ci, co, diff, res;
  status_t         mst_r;
  logic            ov_r;
  vtx_t            ov_vtx_r;
  status_t         ov_st_r;
  logic            ov_last_r;
  logic            out_free, oa, ob, at_last, adv, end_pass;
  logic [VCNT_W-1:0] wr_idx;

  // memory port controls
  logic             wr_en, rd_en;
  logic [AW-1:0]    wr_addr, rd_addr;
  vtx_t             wr_data;
  logic [VTX_W-1:0] rd_bits;

  // plane selection
  logic [AX_W-1:0] ax;
  logic [SL_W-1:0] sl;
  logic signed [NRM_W-1:0]  axx, axy, axz;
  logic signed [DIST_W-1:0] dot_w, hi_w, lo_w;

  function automatic logic [AW-1:0] vaddr(logic bank, logic [VI_W-1:0] idx);
    logic [AW-1:0] base;
    base = bank ? AW'(MAX_VERTS) : AW'(0);
    return base + AW'(idx);
  endfunction

  bpc_ram #(.WIDTH(VTX_W), .DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_bits)
  );

  assign ram_q = vtx_t'(rd_bits);

  // helper terms
  always_comb begin
    ax      = cfg.axis[k_r[2:1]];
    sl      = cfg.slab[k_r[2:1]];
    axx     = signed'(ax[15:0]);
    axy     = signed'(ax[31:16]);
    axz     = signed'(ax[47:32]);
    dot_w   = DIST_W'(prod_r[0]) + DIST_W'(prod_r[1]) + DIST_W'(prod_r[2]);
    hi_w    = DIST_W'(signed'(sl[63:32])) <<< BND_SH;
    lo_w    = DIST_W'(signed'(sl[31:0])) <<< BND_SH;
    a_last  = VI_W'(n_r - 1'b1);
    at_last = a_r == a_last;
    oa      = cur_d_r > 0;
    ob      = prev_d_r > 0;
    nout_nxt = nout_r + CW'(oa);
    cnt_inc = (out_cnt_r < CW'(MAX_VERTS)) ? out_cnt_r + 1'b1 : out_cnt_r;
    cnt_after = (state_r == B_WRX || state_r == B_WRC) ? cnt_inc : out_cnt_r;
    d_in    = oa ? prev_d_r : cur_d_r;
    d_out   = oa ? cur_d_r : prev_d_r;
    in_v    = cx_cur_r ? cur_r : prev_r;
    out_v   = cx_cur_r ? prev_r : cur_r;
    r2      = {rem_r[REM_W-2:0], 1'b0};
    ci      = vtx_comp(in_v, lj_r);
    co      = vtx_comp(out_v, lj_r);
    diff    = co - ci;
    lsh     = lprod_r >>> T_W;
    res     = vtx_comp(in_v, lj_r - 3'd1) + lsh[CMP_W-1:0];
    out_free = !ov_r || out_ch.ready;
    wr_idx  = q_head.cnt - 1'b1;
  end

  // walk step finishes: move on to the next vertex or end the pass
  always_comb begin
    adv = 1'b0;
    unique case (state_r)
      B_DEC:   adv = (phase_r == PH_WALK) && oa && ob;
      B_WRX:   adv = !copy_after_r;
      B_WRC:   adv = 1'b1;
      default: adv = 1'b0;
    endcase
    end_pass = adv && at_last;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (q_valid && q_head.last) state_nxt = q_head.bad ? B_MARK : B_FRD;
      end
      B_FRD:  state_nxt = B_FMUL;
      B_FMUL: state_nxt = B_FSUM;
      B_FSUM: state_nxt = B_DEC;
      B_DEC: begin
        unique case (phase_r)
          PH_CNT:  state_nxt = (at_last && nout_nxt == n_r) ? B_MARK : B_FRD;
          PH_PREV: state_nxt = B_FRD;
          PH_WALK: begin
            if (oa != ob)     state_nxt = B_DIV;
            else if (!oa)     state_nxt = B_WRC;
          end
          default: state_nxt = B_IDLE;
        endcase
      end
      B_DIV:  if (step_r == SW'(T_W - 1)) state_nxt = B_LERP;
      B_LERP: if (lj_r == 3'(NCOMP)) state_nxt = B_WRX;
      B_WRX:  if (copy_after_r) state_nxt = B_WRC;
      B_WRC:  state_nxt = B_WRC;
      B_MARK: if (out_free) state_nxt = B_IDLE;
      B_ERD:  if (out_free) state_nxt = B_ELD;
      B_ELD:  state_nxt = at_last ? B_IDLE : B_ERD;
      default: state_nxt = B_IDLE;
    endcase
    if (adv) begin
      if (!at_last)                         state_nxt = B_FRD;
      else if (k_r == 3'(NPLANES - 1))      state_nxt = B_ERD;
      else                                  state_nxt = B_FRD;
    end
  end

  // memory and queue controls
  always_comb begin
    q_pop   = 1'b0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = cur_r;
    rd_en   = 1'b0;
    rd_addr = vaddr(buf_r, a_r);
    unique case (state_r)
      B_IDLE: begin
        q_pop   = q_valid;
        wr_en   = q_valid && q_head.keep;
        wr_addr = vaddr(1'b0, wr_idx[VI_W-1:0]);
        wr_data = q_head.vtx;
      end
      B_FRD: rd_en = 1'b1;
      B_WRX: begin
        wr_en   = out_cnt_r < CW'(MAX_VERTS);
        wr_addr = vaddr(!buf_r, out_cnt_r[VI_W-1:0]);
        wr_data = nv_r;
      end
      B_WRC: begin
        wr_en   = out_cnt_r < CW'(MAX_VERTS);
        wr_addr = vaddr(!buf_r, out_cnt_r[VI_W-1:0]);
        wr_data = cur_r;
      end
      B_ERD: rd_en = out_free;
      default: rd_en = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      phase_r <= PH_CNT;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_IDLE && q_valid && q_head.last) phase_r <= PH_CNT;
      if (state_r == B_DEC && phase_r == PH_CNT && at_last) phase_r <= PH_PREV;
      if (state_r == B_DEC && phase_r == PH_PREV) phase_r <= PH_WALK;
      if (end_pass) phase_r <= PH_CNT;
      if ((state_r == B_MARK && out_free) || state_r == B_ELD) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        n_r    <= CW'(q_head.cnt);
        k_r    <= '0;
        buf_r  <= 1'b0;
        a_r    <= '0;
        nout_r <= '0;
        mst_r  <= ST_MALFORMED;
      end
      B_FMUL: begin
        cur_r     <= ram_q;
        prod_r[0] <= axx * ram_q.px;
        prod_r[1] <= axy * ram_q.py;
        prod_r[2] <= axz * ram_q.pz;
      end
      B_FSUM: cur_d_r <= k_r[0] ? lo_w - dot_w : dot_w - hi_w;
      B_DEC: begin
        unique case (phase_r)
          PH_CNT: begin
            nout_r <= nout_nxt;
            mst_r  <= ST_CLIPPED;
            a_r    <= at_last ? a_last : a_r + 1'b1;
          end
          PH_PREV: begin
            prev_r    <= cur_r;
            prev_d_r  <= cur_d_r;
            a_r       <= '0;
            out_cnt_r <= '0;
          end
          PH_WALK: begin
            cx_cur_r     <= !oa;
            copy_after_r <= !oa;
            rem_r        <= REM_W'(-d_in);
            den_r        <= REM_W'(d_out - d_in);
            step_r       <= '0;
          end
          default: a_r <= a_r;
        endcase
      end
      B_DIV: begin
        step_r <= step_r + 1'b1;
        lj_r   <= '0;
        if (r2 >= den_r) begin
          rem_r <= r2 - den_r;
          q_r   <= {q_r[T_W-2:0], 1'b1};
        end else begin
          rem_r <= r2;
          q_r   <= {q_r[T_W-2:0], 1'b0};
        end
      end
      B_LERP: begin
        lj_r    <= lj_r + 1'b1;
        lprod_r <= diff * signed'({1'b0, q_r});
        if (lj_r != '0) nv_r <= vtx_set(nv_r, lj_r - 3'd1, res);
      end
      B_WRX, B_WRC: out_cnt_r <= cnt_inc;
      B_ELD: a_r <= a_r + 1'b1;
      default: a_r <= a_r;
    endcase
    // walk advance and end of pass
    if (adv) begin
      prev_r   <= cur_r;
      prev_d_r <= cur_d_r;
      a_r      <= a_r + 1'b1;
    end
    if (end_pass) begin
      n_r    <= cnt_after;
      buf_r  <= !buf_r;
      k_r    <= k_r + 1'b1;
      a_r    <= '0;
      nout_r <= '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (state_r == B_MARK && out_free) begin
      ov_vtx_r  <= '0;
      ov_st_r   <= mst_r;
      ov_last_r <= 1'b1;
    end else if (state_r == B_ELD) begin
      ov_vtx_r  <= ram_q;
      ov_st_r   <= ST_VTX;
      ov_last_r <= at_last;
    end
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.out_px     = ov_vtx_r.px;
  assign out_ch.out_py     = ov_vtx_r.py;
  assign out_ch.out_pz     = ov_vtx_r.pz;
  assign out_ch.out_nx     = ov_vtx_r.nx;
  assign out_ch.out_ny     = ov_vtx_r.ny;
  assign out_ch.out_nz     = ov_vtx_r.nz;
  assign out_ch.out_status = ov_st_r;
  assign out_ch.out_last   = ov_last_r;

endmodule

// ===== hdl/box_polygon_clipper.sv =====
// ----------------------------------------------------------------------------
// box_polygon_clipper
// Clips one polygon per burst of vertices against an oriented box.
// ----------------------------------------------------------------------------
// Front takes one vertex transaction per cycle while its 4-entry queue has room.
// Back: each plane pass fetches the vertices, then per crossing runs 16 divide
// steps, the interpolation and one write, and writes each kept vertex once.
// Once the last pass ends, the result vertices are read out one at a time.
// Reset clears config registers to zero, empties the queue and idles the engine.
module box_polygon_clipper #(
  parameter int IN_VERTS  = 3,
  parameter int MAX_VERTS = 9
) (
  input logic        clk,
  input logic        rst_n,
  bpc_in_if.sink     in_ch,
  bpc_out_if.source  out_ch,
  bpc_cfg_if.sink    cfg_ch
);
  import bpc_pkg::*;

  cfg_t  cfg_r;
  qent_t q_in, q_head;
  logic  q_push, q_full, q_valid, q_pop;

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (reg_idx_t'(cfg_ch.index))
        REG_TAN_AXIS: cfg_r.axis[0] <= cfg_ch.data[AX_W-1:0];
        REG_NRM_AXIS: cfg_r.axis[1] <= cfg_ch.data[AX_W-1:0];
        REG_BIN_AXIS: cfg_r.axis[2] <= cfg_ch.data[AX_W-1:0];
        REG_TAN_SLAB: cfg_r.slab[0] <= cfg_ch.data;
        REG_NRM_SLAB: cfg_r.slab[1] <= cfg_ch.data;
        REG_BIN_SLAB: cfg_r.slab[2] <= cfg_ch.data;
        default:      cfg_r <= cfg_r;
      endcase
    end
  end

  bpc_front #(.IN_VERTS(IN_VERTS)) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .push  (q_push),
    .ent   (q_in),
    .full  (q_full)
  );

  bpc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_ent   (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  bpc_back #(.MAX_VERTS(MAX_VERTS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  // a marker transaction always closes its polygon
  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.out_status != ST_VTX) |-> out_ch.out_last)
    else $error("marker without last");

  // a marker transaction carries zero px and nz components
  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.out_status != ST_VTX) |->
      (out_ch.out_px == '0 && out_ch.out_nz == '0))
    else $error("marker payload not zero");

  // the engine never pops an empty queue entry into a new polygon
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

endmodule
